@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define EPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deframer assertion failed");

// Assertion that is also checked while reset is asserted.
`define EPD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("deframer assertion failed during reset");

`endif

@@ hdl/epd_pkg.sv @@
// ----------------------------------------------------------------------------
// epd_pkg
// Constants, codes and shared types of the event packet deframer.
// ----------------------------------------------------------------------------
package epd_pkg;

    localparam int LATE_CHANNELS  = 8;
    localparam int EARLY_CHANNELS = 8;
    localparam int PACKET_BYTES   = 74;

    localparam int LATE_SAMPLES  = 2 * LATE_CHANNELS;
    localparam int EARLY_SAMPLES = 2 * EARLY_CHANNELS;

    localparam logic [31:0] SYNC_RESET = 32'h8FC7_CDDC;

    // Byte positions inside the packet.
    localparam logic [7:0] HEADER_BYTES = 8'd4;
    localparam logic [7:0] EVNUM_IDX    = 8'd7;
    localparam logic [7:0] COUNT_IDX    = 8'd8;
    localparam logic [7:0] MODE_IDX     = 8'd9;
    localparam logic [7:0] SAMPLE_IDX   = 8'd10;
    localparam logic [7:0] IDX_MAX      = 8'hFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        KIND_EVENT_NUM  = 3'd0,
        KIND_COUNT      = 3'd1,
        KIND_MODES      = 3'd2,
        KIND_LATE_LOW   = 3'd3,
        KIND_LATE_HIGH  = 3'd4,
        KIND_EARLY_LOW  = 3'd5,
        KIND_EARLY_HIGH = 3'd6,
        KIND_STATUS     = 3'd7
    } t_epd_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_LENGTH = 2'd1,
        ST_HEADER = 2'd2
    } t_epd_status;

    // One queue entry: an optional field result and an optional closing status.
    typedef struct packed {
        logic        has_field;
        t_epd_kind   kind;
        logic [7:0]  channel;
        logic [31:0] value;
        logic [7:0]  modes;
        logic        has_status;
        t_epd_status status;
    } t_epd_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_epd_qstat;

endpackage

@@ hdl/epd_if.sv @@
// ----------------------------------------------------------------------------
// epd_if
// Valid/ready channels of the deframer: byte input, result output, config.
// ----------------------------------------------------------------------------
interface epd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface epd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  channel;
    logic [31:0] value;
    logic [2:0]  trigger_mode;
    logic [2:0]  setup_mode;
    logic        trigger_two;
    logic        trigger_one;
    logic        external_in;
    logic [1:0]  status;
    logic        end_of_packet;

    modport source (
        output valid, output kind, output channel, output value,
        output trigger_mode, output setup_mode, output trigger_two,
        output trigger_one, output external_in, output status,
        output end_of_packet, input ready
    );
    modport sink (
        input valid, input kind, input channel, input value,
        input trigger_mode, input setup_mode, input trigger_two,
        input trigger_one, input external_in, input status,
        input end_of_packet, output ready
    );
endinterface

interface epd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] sync_word;

    modport source (output valid, output sync_word, input ready);
    modport sink (input valid, input sync_word, output ready);
endinterface

@@ hdl/epd_front.sv @@
// ----------------------------------------------------------------------------
// epd_front
// Framing front end: tracks the byte position, checks the sync word and
// classifies each byte into a queue entry.
// ----------------------------------------------------------------------------
module epd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    epd_in_if.sink            i_in,
    epd_cfg_if.sink           i_cfg,
    input  logic              i_queue_full,
    output logic              o_push,
    output epd_pkg::t_epd_cmd o_cmd
);
    import epd_pkg::*;

    logic [31:0] r_sync_word;
    logic [7:0]  r_byte_index;
    logic        r_header_good;
    logic [23:0] r_word_assembly;

    logic [7:0]  n_byte_index;
    logic        n_header_good;
    logic [23:0] n_word_assembly;

    logic        accept;
    logic [7:0]  idx;
    logic [7:0]  b;
    logic [7:0]  expect_byte;
    logic [7:0]  sample_off;
    logic [7:0]  s;
    logic [7:0]  e;
    t_epd_cmd    cmd;

    assign i_in.ready  = !i_queue_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_in.ready;
    assign idx         = r_byte_index;
    assign b           = i_in.data_byte;
    assign sample_off  = idx - SAMPLE_IDX;
    assign s           = {1'b0, sample_off[7:1]};
    assign e           = s - 8'(LATE_SAMPLES);

    always_comb begin
        unique case (idx[1:0])
            2'd0: expect_byte = r_sync_word[31:24];
            2'd1: expect_byte = r_sync_word[23:16];
            2'd2: expect_byte = r_sync_word[15:8];
            2'd3: expect_byte = r_sync_word[7:0];
        endcase
    end

    always_comb begin
        n_header_good = r_header_good;
        if (idx < HEADER_BYTES && b != expect_byte) begin
            n_header_good = 1'b0;
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.kind       = KIND_STATUS;
        cmd.status     = ST_OK;
        if (idx >= HEADER_BYTES && idx != IDX_MAX && r_header_good) begin
            priority if (idx == EVNUM_IDX) begin
                cmd.has_field = 1'b1;
                cmd.kind      = KIND_EVENT_NUM;
                cmd.value     = {r_word_assembly, b};
            end else if (idx == COUNT_IDX) begin
                cmd.has_field = 1'b1;
                cmd.kind      = KIND_COUNT;
                cmd.value     = {24'd0, b};
            end else if (idx == MODE_IDX) begin
                cmd.has_field = 1'b1;
                cmd.kind      = KIND_MODES;
                cmd.modes     = b;
            end else if (idx >= SAMPLE_IDX && sample_off[0]) begin
                // Sample completes on its low byte; the high byte is the newest
                // byte held in the assembly register.
                if (s < 8'(LATE_SAMPLES)) begin
                    cmd.has_field = 1'b1;
                    cmd.kind      = s[0] ? KIND_LATE_HIGH : KIND_LATE_LOW;
                    cmd.channel   = {1'b0, s[7:1]};
                    cmd.value     = {16'd0, r_word_assembly[7:0], b};
                end else if (e < 8'(EARLY_SAMPLES)) begin
                    cmd.has_field = 1'b1;
                    cmd.kind      = e[0] ? KIND_EARLY_HIGH : KIND_EARLY_LOW;
                    cmd.channel   = {1'b0, e[7:1]};
                    cmd.value     = {16'd0, r_word_assembly[7:0], b};
                end
            end
        end
        if (i_in.last_byte) begin
            cmd.has_status = 1'b1;
            priority if (idx == IDX_MAX || idx != 8'(PACKET_BYTES - 1)) begin
                cmd.status = ST_LENGTH;
            end else if (!n_header_good) begin
                cmd.status = ST_HEADER;
            end else begin
                cmd.status = ST_OK;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.has_field || cmd.has_status);

    always_comb begin
        n_byte_index    = r_byte_index;
        n_word_assembly = r_word_assembly;
        if (accept) begin
            if (i_in.last_byte) begin
                n_byte_index    = '0;
                n_word_assembly = '0;
            end else begin
                n_byte_index    = (r_byte_index == IDX_MAX) ? IDX_MAX : r_byte_index + 8'd1;
                n_word_assembly = {r_word_assembly[15:0], b};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word     <= SYNC_RESET;
            r_byte_index    <= '0;
            r_header_good   <= 1'b1;
            r_word_assembly <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_sync_word <= i_cfg.sync_word;
            end
            r_byte_index    <= n_byte_index;
            r_word_assembly <= n_word_assembly;
            if (accept) begin
                r_header_good <= i_in.last_byte ? 1'b1 : n_header_good;
            end
        end
    end

endmodule

@@ hdl/epd_queue.sv @@
// ----------------------------------------------------------------------------
// epd_queue
// Short first-in first-out queue of classified entries between the front
// end and the result sequencer.
// ----------------------------------------------------------------------------
module epd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  epd_pkg::t_epd_cmd   i_cmd,
    input  logic                i_pop,
    output epd_pkg::t_epd_cmd   o_cmd,
    output epd_pkg::t_epd_qstat o_stat
);
    import epd_pkg::*;

    t_epd_cmd            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    logic [QUEUE_AW-1:0] n_wr_ptr;
    logic [QUEUE_AW-1:0] n_rd_ptr;
    logic [QUEUE_AW:0]   n_count;
    logic                do_push;
    logic                do_pop;

    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ hdl/epd_back.sv @@
// ----------------------------------------------------------------------------
// epd_back
// Result sequencer: turns each queue entry into one or two result
// transactions through a registered output stage.
// ----------------------------------------------------------------------------
module epd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  epd_pkg::t_epd_cmd   i_cmd,
    input  epd_pkg::t_epd_qstat i_stat,
    output logic                o_pop,
    epd_out_if.source           o_out
);
    import epd_pkg::*;

    logic        r_valid;
    logic        r_pend;
    t_epd_status r_pend_status;
    t_epd_kind   r_kind;
    logic [7:0]  r_channel;
    logic [31:0] r_value;
    logic [7:0]  r_modes;
    t_epd_status r_status;
    logic        r_eop;

    logic        n_valid;
    logic        n_pend;
    t_epd_status n_pend_status;
    t_epd_kind   n_kind;
    logic [7:0]  n_channel;
    logic [31:0] n_value;
    logic [7:0]  n_modes;
    t_epd_status n_status;
    logic        n_eop;

    logic        out_free;

    assign out_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid       = r_valid;
        n_pend        = r_pend;
        n_pend_status = r_pend_status;
        n_kind        = r_kind;
        n_channel     = r_channel;
        n_value       = r_value;
        n_modes       = r_modes;
        n_status      = r_status;
        n_eop         = r_eop;
        o_pop         = 1'b0;
        if (out_free) begin
            priority if (r_pend) begin
                // Status left over from an entry whose field went out first.
                n_valid   = 1'b1;
                n_pend    = 1'b0;
                n_kind    = KIND_STATUS;
                n_channel = '0;
                n_value   = '0;
                n_modes   = '0;
                n_status  = r_pend_status;
                n_eop     = 1'b1;
            end else if (!i_stat.empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                if (i_cmd.has_field) begin
                    n_kind        = i_cmd.kind;
                    n_channel     = i_cmd.channel;
                    n_value       = i_cmd.value;
                    n_modes       = i_cmd.modes;
                    n_status      = ST_OK;
                    n_eop         = 1'b0;
                    n_pend        = i_cmd.has_status;
                    n_pend_status = i_cmd.status;
                end else begin
                    n_kind    = KIND_STATUS;
                    n_channel = '0;
                    n_value   = '0;
                    n_modes   = '0;
                    n_status  = i_cmd.status;
                    n_eop     = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
        r_kind        <= n_kind;
        r_channel     <= n_channel;
        r_value       <= n_value;
        r_modes       <= n_modes;
        r_status      <= n_status;
        r_eop         <= n_eop;
    end

    assign o_out.valid         = r_valid;
    assign o_out.kind          = r_kind;
    assign o_out.channel       = r_channel;
    assign o_out.value         = r_value;
    assign o_out.trigger_mode  = r_modes[7:5];
    assign o_out.setup_mode    = r_modes[5:3];
    assign o_out.trigger_two   = r_modes[2];
    assign o_out.trigger_one   = r_modes[1];
    assign o_out.external_in   = r_modes[0];
    assign o_out.status        = r_status;
    assign o_out.end_of_packet = r_eop;

endmodule

@@ hdl/event_packet_deframer_core.sv @@
// A field result is queued at the accepting edge, then registered in the output stage.
// One byte per cycle while the queue has room; a last byte that ends a field gives two results.
// The four-entry queue between front end and sequencer absorbs those two-result bytes.
// Reset (i_rst_n low at a clock edge) restores the default sync word, restarts framing
// at byte zero and empties the queue and the output register.
// ----------------------------------------------------------------------------
// event_packet_deframer_core
// Byte-serial deframer for detector event packets with a checked sync word.
// ----------------------------------------------------------------------------
module event_packet_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    epd_in_if.sink     i_in,
    epd_cfg_if.sink    i_cfg,
    epd_out_if.source  o_out
);
    import epd_pkg::*;

    // The front end accepts a byte whenever the queue has room. It tracks the
    // byte position, compares the four header bytes against the programmed
    // sync word and assembles multi-byte fields. Each byte that completes a
    // field, or that closes the packet, becomes one queue entry; all other
    // bytes only update the framing state.
    logic       push;
    logic       pop;
    t_epd_cmd   front_cmd;
    t_epd_cmd   head_cmd;
    t_epd_qstat queue_stat;

    epd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .i_queue_full (queue_stat.full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    // The queue decouples the byte side from the result side, so a stalled
    // consumer does not stop input until the queue fills up.
    epd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (queue_stat)
    );

    // The sequencer drives the registered output. An entry that holds both a
    // field and a status sends the field first and the status on the next
    // transaction, with end_of_packet set only on the status.
    epd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_stat  (queue_stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ hdl/epd_checker.sv @@
// ----------------------------------------------------------------------------
// epd_checker
// Port-level checks of the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_kind,
    input logic [31:0] i_out_value,
    input logic [1:0]  i_out_status,
    input logic        i_out_end_of_packet
);
    import epd_pkg::*;

    // The output register is empty right after reset.
    `EPD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

    // A stalled result stays offered.
    `EPD_ASSERT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // A stalled result keeps its payload.
    `EPD_ASSERT(a_hold_data, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_kind) && $stable(i_out_value) && $stable(i_out_status))

    // Only the status result closes a packet, and field results carry no status.
    `EPD_ASSERT(a_eop_kind, i_clk, i_rst_n, i_out_valid |-> (i_out_end_of_packet == (i_out_kind == KIND_STATUS)) && (i_out_end_of_packet || i_out_status == ST_OK))

endmodule

bind event_packet_deframer_core epd_checker u_epd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_kind          (o_out.kind),
    .i_out_value         (o_out.value),
    .i_out_status        (o_out.status),
    .i_out_end_of_packet (o_out.end_of_packet)
);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for event_packet_deframer_core. Byte streams go in
// through a queued driver and decoded fields come out through a monitor. Each
// accepted byte runs through a local decoder model, which predicts the field
// and status results, and the monitor checks every result against them.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import epd_pkg::*;

    // Cycles allowed after the scoreboard empties for anything still in the
    // pipeline; a result passes through the queue and the output register
    // before the block shows it.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BYTES   = 160;
    localparam longint RUN_LIMIT_NS = 5_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_stream_byte;

    typedef struct packed {
        t_epd_kind   kind;
        logic [7:0]  channel;
        logic [31:0] value;
        logic [2:0]  trigger_mode;
        logic [2:0]  setup_mode;
        logic        trigger_two;
        logic        trigger_one;
        logic        external_in;
        t_epd_status status;
        logic        end_of_packet;
    } t_field_result;

    logic clk;
    logic rst_n;

    epd_in_if  byte_if ();
    epd_out_if result_if ();
    epd_cfg_if cfg_if ();

    event_packet_deframer_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_if),
        .i_cfg   (cfg_if),
        .o_out   (result_if)
    );

    // Bytes waiting for the driver and decoded fields waiting for the monitor.
    t_stream_byte  pending_bytes[$];
    t_field_result expected_fields[$];
    t_stream_byte  next_byte;

    // Local copy of the deframer state and of its sync word register.
    logic [31:0] sync_model   = SYNC_RESET;
    logic [7:0]  frame_index  = 8'd0;
    logic        header_ok    = 1'b1;
    logic [23:0] recent_bytes = 24'd0;

    // Traffic shaping, set per phase by the sequence below.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    logic        hold_go   = 1'b0;
    logic        hold_done = 1'b0;

    int unsigned bytes_queued    = 0;
    int unsigned bytes_accepted  = 0;
    int unsigned packets_queued  = 0;
    int unsigned results_checked = 0;
    int unsigned sync_writes     = 0;
    int unsigned status_ok_cnt   = 0;
    int unsigned status_len_cnt  = 0;
    int unsigned status_hdr_cnt  = 0;
    int unsigned error_count     = 0;

    // The clock runs at 100 MHz.
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decoder model. It is called once per accepted byte and pushes the field
    // and status results that byte produces. The order matters: a byte that
    // both completes a field and closes the packet yields the field first.
    // ------------------------------------------------------------------------
    task automatic deframe_byte(input logic [7:0] b, input logic is_last);
        int unsigned   idx;
        int unsigned   sample_num;
        int unsigned   early_num;
        t_field_result fr;
        idx = frame_index;
        fr  = '0;
        if (idx < HEADER_BYTES) begin
            // Sync bytes are compared most significant byte first. One miss
            // spoils the whole packet, so later fields are suppressed.
            if (b != sync_model[31 - 8 * idx -: 8]) begin
                header_ok = 1'b0;
            end
        end else if (idx < IDX_MAX && header_ok) begin
            if (idx == EVNUM_IDX) begin
                fr.kind  = KIND_EVENT_NUM;
                fr.value = {recent_bytes, b};
                expected_fields.push_back(fr);
            end else if (idx == COUNT_IDX) begin
                fr.kind  = KIND_COUNT;
                fr.value = {24'd0, b};
                expected_fields.push_back(fr);
            end else if (idx == MODE_IDX) begin
                fr.kind         = KIND_MODES;
                fr.trigger_mode = b[7:5];
                fr.setup_mode   = b[5:3];
                fr.trigger_two  = b[2];
                fr.trigger_one  = b[1];
                fr.external_in  = b[0];
                expected_fields.push_back(fr);
            end else if (idx >= SAMPLE_IDX && ((idx - SAMPLE_IDX) % 2) == 1) begin
                // Samples are 16-bit big-endian: low gain then high gain for
                // each late channel, then the same for each early channel.
                // Anything past the last early sample is surplus and silent.
                sample_num = (idx - SAMPLE_IDX) / 2;
                fr.value   = {16'd0, recent_bytes[7:0], b};
                if (sample_num < LATE_SAMPLES) begin
                    fr.kind    = sample_num[0] ? KIND_LATE_HIGH : KIND_LATE_LOW;
                    fr.channel = 8'(sample_num / 2);
                    expected_fields.push_back(fr);
                end else if (sample_num - LATE_SAMPLES < EARLY_SAMPLES) begin
                    early_num  = sample_num - LATE_SAMPLES;
                    fr.kind    = early_num[0] ? KIND_EARLY_HIGH : KIND_EARLY_LOW;
                    fr.channel = 8'(early_num / 2);
                    expected_fields.push_back(fr);
                end
            end
        end

        recent_bytes = {recent_bytes[15:0], b};
        // The byte index saturates; a packet that reaches it is always too long.
        if (frame_index < IDX_MAX) begin
            frame_index = frame_index + 8'd1;
        end

        if (is_last) begin
            fr               = '0;
            fr.kind          = KIND_STATUS;
            fr.end_of_packet = 1'b1;
            // The length check wins over the header check.
            if (idx >= IDX_MAX || idx + 1 != PACKET_BYTES) begin
                fr.status = ST_LENGTH;
                status_len_cnt++;
            end else if (!header_ok) begin
                fr.status = ST_HEADER;
                status_hdr_cnt++;
            end else begin
                fr.status = ST_OK;
                status_ok_cnt++;
            end
            expected_fields.push_back(fr);
            frame_index  = 8'd0;
            header_ok    = 1'b1;
            recent_bytes = 24'd0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. A transaction completes at an edge where valid and ready were
    // both high; that byte goes to the decoder model, and a new byte (or an
    // idle cycle) is offered only once the current one has been taken.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            byte_if.valid <= 1'b0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                deframe_byte(byte_if.data_byte, byte_if.last_byte);
                bytes_accepted++;
            end
            if (!byte_if.valid || byte_if.ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_byte = pending_bytes.pop_front();
                    byte_if.valid     <= 1'b1;
                    byte_if.data_byte <= next_byte.data;
                    byte_if.last_byte <= next_byte.is_last;
                end else begin
                    byte_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: result %0d, %s mismatch: expected %0h, actual %0h",
                     $time, results_checked, field, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Each result transaction is compared field by field with the
    // oldest prediction. Ready follows the stall rate of the phase and is
    // forced low while the long receiver hold-off is running.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_monitor
        t_field_result want;
        if (!rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (expected_fields.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, actual kind %0d value %0h",
                             $time, result_if.kind, result_if.value);
                end else begin
                    want = expected_fields.pop_front();
                    check_field("kind", 32'(want.kind), 32'(result_if.kind));
                    check_field("channel", 32'(want.channel), 32'(result_if.channel));
                    check_field("value", want.value, result_if.value);
                    check_field("trigger_mode", 32'(want.trigger_mode),
                                32'(result_if.trigger_mode));
                    check_field("setup_mode", 32'(want.setup_mode),
                                32'(result_if.setup_mode));
                    check_field("trigger_two", 32'(want.trigger_two),
                                32'(result_if.trigger_two));
                    check_field("trigger_one", 32'(want.trigger_one),
                                32'(result_if.trigger_one));
                    check_field("external_in", 32'(want.external_in),
                                32'(result_if.external_in));
                    check_field("status", 32'(want.status), 32'(result_if.status));
                    check_field("end_of_packet", 32'(want.end_of_packet),
                                32'(result_if.end_of_packet));
                end
                results_checked++;
            end
            result_if.ready <= !(hold_go && !hold_done) && ($urandom_range(99) >= stall_pct);
        end
    end

    // The long receiver hold-off is timed here, apart from the monitor, so that
    // the output queue fills and the block has to push back on its input.
    initial begin : receiver_hold
        wait (hold_go);
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
    end

    // Overall watchdog.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached with %0d results outstanding",
                 $time, expected_fields.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_byte(input logic [7:0] data, input logic is_last);
        t_stream_byte sb;
        sb.data    = data;
        sb.is_last = is_last;
        pending_bytes.push_back(sb);
        bytes_queued++;
        if (is_last) begin
            packets_queued++;
        end
    endtask

    // A packet of n_bytes with the current sync word in front; the sync byte
    // at bad_pos (if it is one of the four) is corrupted.
    task automatic queue_packet(input int n_bytes, input int bad_pos);
        logic [7:0] data;
        for (int i = 0; i < n_bytes; i++) begin
            if (i < 4) begin
                data = sync_model[31 - 8 * i -: 8];
                if (i == bad_pos) begin
                    data ^= 8'($urandom_range(255, 1));
                end
            end else begin
                data = pick_byte();
            end
            queue_byte(data, i == n_bytes - 1);
        end
    endtask

    // Unframed bytes with a scattered last flag, closed by a last byte.
    task automatic queue_noise(input int n_bytes);
        for (int i = 0; i < n_bytes; i++) begin
            queue_byte(pick_byte(), (i == n_bytes - 1) || ($urandom_range(9) == 0));
        end
    endtask

    // Waits until every queued byte is taken and every prediction has been
    // matched, then lets the pipeline settle.
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        while ((bytes_accepted != bytes_queued || expected_fields.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT) begin
            error_count++;
            $display("%0t: drain stalled: expected %0d more results, actual none",
                     $time, expected_fields.size());
            expected_fields.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sync_word(input logic [31:0] word);
        @(posedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.sync_word <= word;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sync_model = word;
        sync_writes++;
    endtask

    // Starts a phase: new sync word, new idle and stall rates.
    task automatic start_phase(input logic [31:0] word, input int unsigned idle,
                               input int unsigned stall);
        write_sync_word(word);
        send_idle_pct = idle;
        stall_pct     = stall;
    endtask

    // Mostly well-formed packets with random content; the rest are bad sync
    // words, short and long packets, and loose bytes.
    task automatic run_random_traffic(input int byte_budget, input bit pause_each);
        int unsigned start;
        int unsigned pick;
        start = bytes_queued;
        while (bytes_queued - start < byte_budget) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                queue_packet(PACKET_BYTES, -1);
            end else if (pick < 80) begin
                queue_packet(PACKET_BYTES, int'($urandom_range(3)));
            end else if (pick < 87) begin
                queue_packet(int'($urandom_range(PACKET_BYTES - 1, 1)),
                             int'($urandom_range(7)));
            end else if (pick < 94) begin
                queue_packet(int'($urandom_range(PACKET_BYTES + 20, PACKET_BYTES + 1)),
                             int'($urandom_range(7)));
            end else begin
                queue_noise(int'($urandom_range(12, 1)));
            end
            if (pause_each) begin
                wait_for_drain();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : sequence_main
        byte_if.valid     = 1'b0;
        byte_if.data_byte = 8'd0;
        byte_if.last_byte = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.sync_word  = 32'd0;
        result_if.ready   = 1'b0;
        rst_n             = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, on the sync word left by reset. A lone last byte
        // gives a length error. A ten-byte packet ends on the mode byte, so
        // one byte yields both a field and the status, with an all-ones event
        // number and a zero count. A short packet with a broken sync byte
        // shows that the length error wins over the header error.
        queue_byte(8'h00, 1'b1);
        for (int i = 0; i < 4; i++) begin
            queue_byte(sync_model[31 - 8 * i -: 8], 1'b0);
        end
        repeat (4) queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_packet(12, 3);
        wait_for_drain();

        // Back to back, all-zero sync word; one packet runs the byte index
        // into saturation.
        start_phase(32'h0000_0000, 0, 0);
        queue_packet(260, -1);
        run_random_traffic(PHASE_BYTES, 1'b0);
        wait_for_drain();

        // Bursty sender, all-ones sync word.
        start_phase(32'hFFFF_FFFF, 58, 0);
        run_random_traffic(PHASE_BYTES, 1'b0);
        wait_for_drain();

        // Stalling receiver, random sync word.
        start_phase($urandom, 0, 58);
        run_random_traffic(PHASE_BYTES, 1'b0);
        wait_for_drain();

        // Both sides idle, default sync word written back explicitly.
        start_phase(SYNC_RESET, 30, 30);
        run_random_traffic(PHASE_BYTES, 1'b0);
        wait_for_drain();

        // Receiver holds off for a long stretch while the sender keeps
        // offering bytes, so the internal queue fills and input stalls.
        start_phase($urandom, 0, 0);
        hold_go <= 1'b1;
        run_random_traffic(PHASE_BYTES, 1'b0);
        wait_for_drain();

        // Sender waits for every result of a packet before the next one.
        start_phase($urandom, 30, 30);
        run_random_traffic(PHASE_BYTES, 1'b1);
        wait_for_drain();

        $display("Run covered %0d bytes in %0d packets under %0d sync word settings,",
                 bytes_accepted, packets_queued, sync_writes + 1);
        $display("%0d results checked; packet status: %0d good, %0d wrong length, %0d bad header.",
                 results_checked, status_ok_cnt, status_len_cnt, status_hdr_cnt);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
